FILE: hdl/art_pkg.sv
// ----------------------------------------------------------------------------
// art_pkg: shared types and constants of the address range table
// Holds the operation codes and the controller/datapath command and status
// bundles.
// ----------------------------------------------------------------------------
package art_pkg;

    typedef enum logic [1:0] {
        KIND_ADD   = 2'd0,
        KIND_SUB   = 2'd1,
        KIND_QUERY = 2'd2,
        KIND_NTH   = 2'd3
    } kind_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [63:0] addr_first;
        logic [63:0] addr_second;
        logic        allow_new;
        logic [7:0]  entry_index;
    } in_item_t;

    typedef struct packed {
        logic        hit;
        logic [63:0] found_low;
        logic [63:0] found_high;
        logic        found_valid;
        logic        table_changed;
        logic        table_full;
        logic [8:0]  entry_count;
        logic [63:0] total_size;
    } out_item_t;

    // Datapath commands issued by the controller
    typedef enum logic [3:0] {
        CMD_NONE    = 4'd0,
        CMD_LOAD    = 4'd1,  // latch input item, order bounds, clear flags
        CMD_SCAN    = 4'd2,  // add, query or subtract step on one entry
        CMD_APPEND  = 4'd3,  // append after add scan if needed
        CMD_SHIFT   = 4'd4,  // compaction: copy entry k+1 to k
        CMD_SPLIT   = 4'd5,  // start upper-remainder add
        CMD_SORTSTP = 4'd6,  // one insertion-sort compare/move step
        CMD_NTHRD   = 4'd7,  // read nth entry
        CMD_SUM     = 4'd8,  // accumulate total size over one entry
        CMD_RESTART = 4'd9   // begin a new subtract pass
    } cmd_t;

    typedef struct packed {
        cmd_t cmd;
    } art_ctl_t;

    typedef struct packed {
        logic scan_last;    // current index is last used entry or none used
        logic empty_sub;    // subtract with equal bounds
        logic sub_delete;   // current entry must be deleted
        logic sub_split;    // current entry must be split
        logic shift_last;   // compaction reached the end
        logic sort_done;    // insertion sort finished
        logic sort_move;    // current sort step moves an entry
        logic split_add;    // running the upper-remainder add
        logic rescans_out;  // rescan budget used up
    } art_sts_t;

endpackage

FILE: hdl/art_dp.sv
// ----------------------------------------------------------------------------
// art_dp: address range table datapath
// Entry registers, one entry compared or moved per cycle under controller
// command; flags, found entry and size sum.
// ----------------------------------------------------------------------------
module art_dp #(
    parameter int ENTRIES = 16
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  art_pkg::in_item_t  in_item,
    input  art_pkg::art_ctl_t  ctl,
    output art_pkg::art_sts_t  sts,
    output art_pkg::out_item_t out_item
);
    import art_pkg::*;

    localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CW = $clog2(ENTRIES + 1);
    localparam int RW = $clog2(4 * ENTRIES + 6);

    logic [63:0] starts_reg [ENTRIES];
    logic [63:0] ends_reg   [ENTRIES];
    logic [CW-1:0] used_reg;
    logic [IW-1:0] idx_reg, j_reg;
    logic [CW-1:0] sort_i_reg;
    logic [RW-1:0] rescans_reg;
    logic [63:0] lo_reg, hi_reg, key_s_reg, key_e_reg, total_reg;
    logic [63:0] save_lo_reg, save_hi_reg;
    logic [1:0]  kind_reg;
    logic [7:0]  nth_reg;
    logic        allow_reg, any_reg, ret_ok_reg, changed_reg, full_reg;
    logic        split_reg, qhit_reg, qval_reg, sort_run_reg;
    logic [IW-1:0] ret_reg;
    logic [63:0] flo_reg, fhi_reg;

    logic [63:0] s, e;
    logic [CW-1:0] idx_ext;
    logic        c_eq, c_low, c_high, c_cov, c_in;
    logic        t_low, t_high, d_in, d_split;
    logic [63:0] s_t, e_t;

    assign s = starts_reg[idx_reg];
    assign e = ends_reg[idx_reg];
    assign idx_ext = CW'(idx_reg);

    // Add merge cases in priority order; subtract trim, delete and split cases
    always_comb begin
        c_eq   = (s == lo_reg) && (e == hi_reg);
        c_low  = !c_eq && s <= lo_reg && e >= lo_reg && e <= hi_reg;
        c_high = !c_eq && !c_low && s >= lo_reg && s <= hi_reg && e >= hi_reg;
        c_cov  = !c_eq && !c_low && !c_high && s <= lo_reg && e >= hi_reg;
        c_in   = !c_eq && !c_low && !c_high && !c_cov &&
                 s >= lo_reg && s <= hi_reg && e >= lo_reg && e <= hi_reg;
        t_low  = s < lo_reg && e > lo_reg && e < hi_reg;
        t_high = !t_low && s > lo_reg && s < hi_reg && e > hi_reg;
        s_t    = t_high ? hi_reg : s;
        e_t    = t_low ? lo_reg : e;
        d_in   = s_t > lo_reg && s_t < hi_reg && e_t > lo_reg && e_t < hi_reg;
        d_split = !d_in && s_t < lo_reg && e_t > lo_reg && e_t > hi_reg;
    end

    always_comb begin
        sts.scan_last   = (used_reg == '0) || (idx_ext + 1'b1 >= used_reg);
        sts.empty_sub   = (lo_reg == hi_reg);
        // an empty table has no entry to delete or split
        sts.sub_delete  = d_in && (used_reg != '0);
        sts.sub_split   = d_split && (used_reg != '0);
        sts.shift_last  = (idx_ext + 1'b1 >= used_reg);
        sts.sort_done   = (sort_i_reg >= used_reg);
        sts.sort_move   = sort_run_reg && (j_reg != '0) &&
                          (starts_reg[j_reg - 1'b1] > key_s_reg);
        sts.split_add   = split_reg;
        sts.rescans_out = (rescans_reg > RW'(4 * ENTRIES + 4));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            used_reg <= '0;
        end else begin
            case (ctl.cmd)
                CMD_LOAD: begin
                    kind_reg  <= in_item.kind;
                    allow_reg <= in_item.allow_new;
                    nth_reg   <= in_item.entry_index;
                    // a query keeps its address as given
                    if (in_item.kind != KIND_QUERY &&
                        in_item.addr_first > in_item.addr_second) begin
                        lo_reg <= in_item.addr_second;
                        hi_reg <= in_item.addr_first;
                    end else begin
                        lo_reg <= in_item.addr_first;
                        hi_reg <= in_item.addr_second;
                    end
                    idx_reg <= '0; any_reg <= 1'b0; ret_ok_reg <= 1'b0;
                    changed_reg <= 1'b0; full_reg <= 1'b0; split_reg <= 1'b0;
                    qhit_reg <= 1'b0; qval_reg <= 1'b0;
                    flo_reg <= '0; fhi_reg <= '0; total_reg <= '0;
                    rescans_reg <= RW'(1);
                    sort_i_reg <= CW'(1); sort_run_reg <= 1'b0;
                end
                CMD_RESTART: begin
                    idx_reg <= '0;
                    rescans_reg <= rescans_reg + 1'b1;
                end
                CMD_SCAN: begin
                    if (used_reg != '0) begin
                        if (kind_reg == KIND_QUERY) begin
                            if (lo_reg >= s && lo_reg <= e) qhit_reg <= 1'b1;
                            if (!qval_reg && lo_reg >= s && lo_reg < e) begin
                                qval_reg <= 1'b1; flo_reg <= s; fhi_reg <= e;
                            end
                        end else if (kind_reg == KIND_SUB && !split_reg) begin
                            starts_reg[idx_reg] <= s_t;
                            ends_reg[idx_reg]   <= d_split ? lo_reg : e_t;
                            if (d_split) begin
                                save_lo_reg <= lo_reg; save_hi_reg <= hi_reg;
                                lo_reg <= hi_reg; hi_reg <= e_t;
                            end
                        end else begin
                            if (c_eq || c_cov) any_reg <= 1'b1;
                            if (c_low) begin
                                ends_reg[idx_reg] <= hi_reg;
                                any_reg <= 1'b1; ret_ok_reg <= 1'b1; ret_reg <= idx_reg;
                            end
                            if (c_high) begin
                                starts_reg[idx_reg] <= lo_reg;
                                any_reg <= 1'b1; ret_ok_reg <= 1'b1; ret_reg <= idx_reg;
                            end
                            if (c_in) begin
                                starts_reg[idx_reg] <= lo_reg; ends_reg[idx_reg] <= hi_reg;
                                any_reg <= 1'b1; ret_ok_reg <= 1'b1; ret_reg <= idx_reg;
                            end
                        end
                    end
                    // rewind after the last entry so the size sum starts at entry zero
                    if (!sts.scan_last) idx_reg <= idx_reg + 1'b1;
                    else idx_reg <= '0;
                end
                CMD_SPLIT: begin
                    split_reg <= 1'b1; idx_reg <= '0; any_reg <= 1'b0;
                end
                CMD_APPEND: begin
                    if ((allow_reg || split_reg) && !any_reg) begin
                        if (used_reg < CW'(ENTRIES)) begin
                            starts_reg[used_reg[IW-1:0]] <= lo_reg;
                            ends_reg[used_reg[IW-1:0]]   <= hi_reg;
                            ret_ok_reg <= 1'b1; ret_reg <= used_reg[IW-1:0];
                            used_reg <= used_reg + 1'b1;
                            changed_reg <= 1'b1;
                        end else begin
                            full_reg <= 1'b1;
                        end
                    end
                    if (split_reg) begin
                        split_reg <= 1'b0;
                        lo_reg <= save_lo_reg; hi_reg <= save_hi_reg;
                    end
                end
                CMD_SHIFT: begin
                    if (sts.shift_last) begin
                        used_reg <= used_reg - 1'b1;
                        changed_reg <= 1'b1;
                    end else begin
                        starts_reg[idx_reg] <= starts_reg[idx_reg + 1'b1];
                        ends_reg[idx_reg]   <= ends_reg[idx_reg + 1'b1];
                        idx_reg <= idx_reg + 1'b1;
                    end
                end
                CMD_SORTSTP: begin
                    if (!sort_run_reg) begin
                        key_s_reg <= starts_reg[sort_i_reg[IW-1:0]];
                        key_e_reg <= ends_reg[sort_i_reg[IW-1:0]];
                        j_reg <= sort_i_reg[IW-1:0];
                        sort_run_reg <= 1'b1;
                    end else if (sts.sort_move) begin
                        starts_reg[j_reg] <= starts_reg[j_reg - 1'b1];
                        ends_reg[j_reg]   <= ends_reg[j_reg - 1'b1];
                        j_reg <= j_reg - 1'b1;
                    end else begin
                        starts_reg[j_reg] <= key_s_reg;
                        ends_reg[j_reg]   <= key_e_reg;
                        sort_run_reg <= 1'b0;
                        sort_i_reg <= sort_i_reg + 1'b1;
                    end
                end
                CMD_NTHRD: begin
                    idx_reg <= '0;
                    if ({1'b0, nth_reg} < 9'(used_reg)) begin
                        qhit_reg <= 1'b1; qval_reg <= 1'b1;
                        flo_reg <= starts_reg[nth_reg[IW-1:0]];
                        fhi_reg <= ends_reg[nth_reg[IW-1:0]];
                    end
                end
                CMD_SUM: begin
                    if (used_reg != '0) total_reg <= total_reg + (e - s);
                    if (!sts.scan_last) idx_reg <= idx_reg + 1'b1;
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        out_item.hit           = (kind_reg == KIND_ADD) ? any_reg :
                                 (kind_reg == KIND_SUB) ? 1'b0 : qhit_reg;
        out_item.found_valid   = 1'b0;
        out_item.found_low     = '0;
        out_item.found_high    = '0;
        case (kind_reg)
            KIND_ADD: begin
                out_item.found_valid = ret_ok_reg;
                if (ret_ok_reg) begin
                    out_item.found_low  = starts_reg[ret_reg];
                    out_item.found_high = ends_reg[ret_reg];
                end
            end
            KIND_QUERY, KIND_NTH: begin
                out_item.found_valid = qval_reg;
                out_item.found_low   = flo_reg;
                out_item.found_high  = fhi_reg;
            end
            default: begin
            end
        endcase
        out_item.table_changed = changed_reg;
        out_item.table_full    = full_reg;
        out_item.entry_count   = 9'(used_reg);
        out_item.total_size    = total_reg;
    end

endmodule

FILE: hdl/art_ctrl.sv
// ----------------------------------------------------------------------------
// art_ctrl: address range table controller
// Sequences the entry walks of each operation and the result handshake.
// ----------------------------------------------------------------------------
module art_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    output logic              in_ready,
    output logic              out_valid,
    input  logic              out_ready,
    input  logic [1:0]        kind,
    input  art_pkg::art_sts_t sts,
    output art_pkg::art_ctl_t ctl,
    output logic              out_load
);
    import art_pkg::*;

    typedef enum logic [8:0] {
        ST_IDLE   = 9'b000000001,
        ST_SCAN   = 9'b000000010,
        ST_APPEND = 9'b000000100,
        ST_SHIFT  = 9'b000001000,
        ST_RESCAN = 9'b000010000,
        ST_SORT   = 9'b000100000,
        ST_NTH    = 9'b001000000,
        ST_SUM    = 9'b010000000,
        ST_DONE   = 9'b100000000
    } state_t;

    state_t state_reg, state_next;
    logic   [1:0] kind_reg;
    logic   ovalid_reg;

    assign out_valid = ovalid_reg;
    assign in_ready  = (state_reg == ST_IDLE) && !ovalid_reg;
    assign out_load  = (state_reg == ST_DONE);

    always_comb begin
        state_next = state_reg;
        ctl.cmd    = CMD_NONE;
        case (state_reg)
            ST_IDLE: begin
                if (in_valid && in_ready) begin
                    ctl.cmd = CMD_LOAD;
                    case (kind)
                        KIND_NTH: state_next = ST_SORT;
                        default:  state_next = ST_SCAN;
                    endcase
                end
            end
            ST_SCAN: begin
                if (kind_reg == KIND_SUB && sts.empty_sub) begin
                    state_next = ST_SUM;
                end else if (kind_reg == KIND_SUB && !sts.split_add && sts.sub_delete) begin
                    state_next = ST_SHIFT;
                end else if (kind_reg == KIND_SUB && !sts.split_add && sts.sub_split) begin
                    ctl.cmd = CMD_SCAN;
                    state_next = ST_RESCAN;
                end else begin
                    ctl.cmd = CMD_SCAN;
                    if (sts.scan_last) begin
                        if (kind_reg == KIND_ADD || sts.split_add) state_next = ST_APPEND;
                        else state_next = ST_SUM;
                    end
                end
            end
            ST_RESCAN: begin
                ctl.cmd = CMD_SPLIT;
                state_next = ST_SCAN;
            end
            ST_APPEND: begin
                ctl.cmd = CMD_APPEND;
                // after a split's upper-remainder add, start another subtract pass
                if (sts.split_add) state_next = ST_NTH;
                else state_next = ST_SUM;
            end
            ST_SHIFT: begin
                ctl.cmd = CMD_SHIFT;
                if (sts.shift_last) state_next = ST_NTH;
            end
            ST_NTH: begin
                if (kind_reg == KIND_SUB) begin
                    // rewind the index; stop once the pass budget is spent
                    ctl.cmd = CMD_RESTART;
                    if (sts.rescans_out) state_next = ST_SUM;
                    else state_next = ST_SCAN;
                end else begin
                    ctl.cmd = CMD_NTHRD;
                    state_next = ST_SUM;
                end
            end
            ST_SORT: begin
                if (sts.sort_done) begin
                    state_next = ST_NTH;
                end else begin
                    ctl.cmd = CMD_SORTSTP;
                end
            end
            ST_SUM: begin
                ctl.cmd = CMD_SUM;
                if (sts.scan_last) state_next = ST_DONE;
            end
            ST_DONE: begin
                state_next = ST_IDLE;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            ovalid_reg <= 1'b0;
            kind_reg   <= KIND_ADD;
        end else begin
            state_reg <= state_next;
            if (ctl.cmd == CMD_LOAD) kind_reg <= kind;
            if (state_reg == ST_DONE) ovalid_reg <= 1'b1;
            else if (out_ready) ovalid_reg <= 1'b0;
        end
    end

    // Result is only raised once the walk finished
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(ovalid_reg) |-> $past(state_reg) == ST_DONE)
        else $error("result raised outside done");
    // No item accepted while a result waits
    assert property (@(posedge aclk) disable iff (!aresetn)
        ovalid_reg |-> !in_ready)
        else $error("accept while result pending");
    // Load only from idle
    assert property (@(posedge aclk) disable iff (!aresetn)
        ctl.cmd == CMD_LOAD |-> state_reg == ST_IDLE)
        else $error("load outside idle");

endmodule

FILE: hdl/address_range_table.sv
// ----------------------------------------------------------------------------
// address_range_table: ordered table of address ranges
// Add, subtract, address query and nth-entry lookup over up to ENTRIES
// ranges, one operation per beat, with entry count and summed size.
// ----------------------------------------------------------------------------
// One beat is processed at a time. The controller walks the entry registers
// one used entry per cycle; an empty table still gets a scan step. Between
// the accepting edge and the result beat going valid: a query runs one walk,
// a size-sum walk and the done state; an add runs one walk, an append step,
// the size-sum walk and the done state; an empty subtract skips straight to
// the size sum. A subtract restarts its walk after every delete (plus a
// compaction walk to the table end and a restart step) or split (plus a
// split step, a full add walk, an append step and a restart step), for at
// most 4*ENTRIES+5 passes. Nth first runs an insertion sort: per entry after
// the first, a load step, a move step per entry moved and a write step, then
// a read step before the size sum. The result beat is held until taken; the
// next beat is accepted from the cycle after that.
module address_range_table #(
    parameter int ENTRIES = 16
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // tdata: addr_first[63:0], addr_second[127:64], allow_new[128],
    //        entry_index[136:129], zero fill [143:137]
    input  logic [143:0] s_tdata,
    // tuser: kind
    input  logic [1:0]   s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // tdata: hit[0], found_low[64:1], found_high[128:65], found_valid[129],
    //        table_changed[130], table_full[131], entry_count[140:132],
    //        total_size[204:141], zero fill [207:205]
    output logic [207:0] m_tdata
);
    import art_pkg::*;

    in_item_t  in_item;
    out_item_t out_item;
    art_ctl_t  ctl;
    art_sts_t  sts;
    logic      out_load;
    logic [207:0] res_reg;

    assign in_item.kind        = s_tuser;
    assign in_item.addr_first  = s_tdata[63:0];
    assign in_item.addr_second = s_tdata[127:64];
    assign in_item.allow_new   = s_tdata[128];
    assign in_item.entry_index = s_tdata[136:129];

    art_ctrl u_ctrl (
        .aclk, .aresetn,
        .in_valid(s_tvalid), .in_ready(s_tready),
        .out_valid(m_tvalid), .out_ready(m_tready),
        .kind(s_tuser), .sts, .ctl, .out_load
    );

    art_dp #(.ENTRIES(ENTRIES)) u_dp (
        .aclk, .aresetn, .in_item, .ctl, .sts, .out_item
    );

    // Hold the result beat in an output register
    always_ff @(posedge aclk) begin
        if (out_load) begin
            res_reg <= {3'b000, out_item.total_size, out_item.entry_count,
                        out_item.table_full, out_item.table_changed,
                        out_item.found_valid, out_item.found_high,
                        out_item.found_low, out_item.hit};
        end
    end

    assign m_tdata = res_reg;

endmodule

FILE: tb/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for address_range_table
// Drives add, subtract, query and nth beats over the stream ports, predicts
// every result beat with a behavioral copy of the range table and compares
// field by field, under random source and sink stalls.
// ----------------------------------------------------------------------------
module testbench;
    import art_pkg::*;

    localparam int ENTRIES = 16;
    localparam int WATCHDOG_CYCLES = 200000;

    logic         aclk;
    logic         aresetn;
    logic         s_tvalid;
    logic         s_tready;
    logic [143:0] s_tdata;
    logic [1:0]   s_tuser;
    logic         m_tvalid;
    logic         m_tready;
    logic [207:0] m_tdata;

    address_range_table #(.ENTRIES(ENTRIES)) uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    always begin
        aclk = 1'b0;
        #5;
        aclk = 1'b1;
        #5;
    end

    // Predicted table contents, kept in the same order as the block's own registers
    logic [63:0] tbl_start [ENTRIES];
    logic [63:0] tbl_end   [ENTRIES];
    int          tbl_used;
    bit          step_changed;
    bit          step_full;

    out_item_t   pending_results [$];
    int          error_count;
    int          beats_sent;
    int          results_seen;
    int          sender_idle_pct;
    int          receiver_idle_pct;
    int          idle_cycles;
    int          kind_seen [4];

    // Merge a range into the table; returns index of modified/appended entry or -1
    function automatic int merge_range(logic [63:0] lo_in, logic [63:0] hi_in, bit allow,
                                       output bit matched);
        logic [63:0] lo, hi, s, e;
        int ret;
        ret = -1;
        matched = 1'b0;
        lo = (lo_in > hi_in) ? hi_in : lo_in;
        hi = (lo_in > hi_in) ? lo_in : hi_in;
        for (int i = 0; i < tbl_used; i++) begin
            s = tbl_start[i];
            e = tbl_end[i];
            if (s == lo && e == hi) begin
                matched = 1'b1;
            end else if (s <= lo && e >= lo && e <= hi) begin
                tbl_end[i] = hi; ret = i; matched = 1'b1;
            end else if (s >= lo && s <= hi && e >= hi) begin
                tbl_start[i] = lo; ret = i; matched = 1'b1;
            end else if (s <= lo && e >= hi) begin
                matched = 1'b1;
            end else if (s >= lo && s <= hi && e <= hi) begin
                tbl_start[i] = lo; tbl_end[i] = hi; ret = i; matched = 1'b1;
            end
        end
        if (allow && !matched) begin
            if (tbl_used < ENTRIES) begin
                tbl_start[tbl_used] = lo;
                tbl_end[tbl_used] = hi;
                ret = tbl_used;
                tbl_used++;
                step_changed = 1'b1;
            end else begin
                step_full = 1'b1;
            end
        end
        return ret;
    endfunction

    // Cut a range out of the table, rescanning after each delete or split
    function automatic void cut_range(logic [63:0] lo_in, logic [63:0] hi_in);
        logic [63:0] lo, hi, s, e;
        int rescans;
        bit again, m;
        int dummy;
        lo = (lo_in > hi_in) ? hi_in : lo_in;
        hi = (lo_in > hi_in) ? lo_in : hi_in;
        if (lo == hi) return;
        rescans = 0;
        again = 1'b1;
        while (again && rescans <= 4 * ENTRIES + 4) begin
            again = 1'b0;
            rescans++;
            for (int i = 0; i < tbl_used; i++) begin
                s = tbl_start[i];
                e = tbl_end[i];
                if (s < lo && e > lo && e < hi) begin
                    tbl_end[i] = lo; e = lo;
                end else if (s > lo && s < hi && e > hi) begin
                    tbl_start[i] = hi; s = hi;
                end
                if (s > lo && s < hi && e > lo && e < hi) begin
                    for (int k = i; k + 1 < tbl_used; k++) begin
                        tbl_start[k] = tbl_start[k + 1];
                        tbl_end[k] = tbl_end[k + 1];
                    end
                    tbl_used--;
                    step_changed = 1'b1;
                    again = 1'b1;
                    break;
                end
                if (s < lo && e > lo && e > hi) begin
                    tbl_end[i] = lo;
                    dummy = merge_range(hi, e, 1'b1, m);
                    again = 1'b1;
                    break;
                end
            end
        end
    endfunction

    function automatic out_item_t predict_result(kind_t kind, logic [63:0] a, logic [63:0] b,
                                                 bit allow, logic [7:0] idx);
        out_item_t r;
        int pos, j;
        bit m;
        logic [63:0] ks, ke;
        r = '0;
        step_changed = 1'b0;
        step_full = 1'b0;
        case (kind)
            KIND_ADD: begin
                pos = merge_range(a, b, allow, m);
                r.hit = m;
                if (pos >= 0) begin
                    r.found_valid = 1'b1;
                    r.found_low = tbl_start[pos];
                    r.found_high = tbl_end[pos];
                end
            end
            KIND_SUB: begin
                cut_range(a, b);
            end
            KIND_QUERY: begin
                for (int i = 0; i < tbl_used; i++) begin
                    if (a >= tbl_start[i] && a <= tbl_end[i]) r.hit = 1'b1;
                    if (!r.found_valid && a >= tbl_start[i] && a < tbl_end[i]) begin
                        r.found_valid = 1'b1;
                        r.found_low = tbl_start[i];
                        r.found_high = tbl_end[i];
                    end
                end
            end
            default: begin
                // stable insertion sort by start, left in place
                for (int i = 1; i < tbl_used; i++) begin
                    ks = tbl_start[i];
                    ke = tbl_end[i];
                    j = i;
                    while (j > 0 && tbl_start[j - 1] > ks) begin
                        tbl_start[j] = tbl_start[j - 1];
                        tbl_end[j] = tbl_end[j - 1];
                        j--;
                    end
                    tbl_start[j] = ks;
                    tbl_end[j] = ke;
                end
                if (idx < tbl_used) begin
                    r.hit = 1'b1;
                    r.found_valid = 1'b1;
                    r.found_low = tbl_start[idx];
                    r.found_high = tbl_end[idx];
                end
            end
        endcase
        r.table_changed = step_changed;
        r.table_full = step_full;
        r.entry_count = 9'(tbl_used);
        for (int i = 0; i < tbl_used; i++) r.total_size += tbl_end[i] - tbl_start[i];
        return r;
    endfunction

    task automatic report_mismatch(string field, logic [63:0] got, logic [63:0] want);
        error_count++;
        if (error_count <= 40)
            $display("MISMATCH result %0d %s: got %h expected %h", results_seen, field, got,
                     want);
    endtask

    // Send one beat; predict when it is accepted. tvalid stays up after the
    // accepting edge; a drain, or an idle draw at the start of the next send, drops it.
    task automatic send_op(kind_t kind, logic [63:0] a, logic [63:0] b, bit allow,
                           logic [7:0] idx);
        while ($urandom_range(99) < sender_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= kind;
        s_tdata <= {7'd0, idx, allow, b, a};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        pending_results.push_back(predict_result(kind, a, b, allow, idx));
        kind_seen[kind]++;
        beats_sent++;
    endtask

    // Drop tvalid and hold until every expected result has arrived
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending_results.size() != 0) @(posedge aclk);
    endtask

    // Check each result beat against the oldest prediction
    always @(posedge aclk) begin
        out_item_t got, want;
        if (aresetn && m_tvalid && m_tready) begin
            got.hit           = m_tdata[0];
            got.found_low     = m_tdata[64:1];
            got.found_high    = m_tdata[128:65];
            got.found_valid   = m_tdata[129];
            got.table_changed = m_tdata[130];
            got.table_full    = m_tdata[131];
            got.entry_count   = m_tdata[140:132];
            got.total_size    = m_tdata[204:141];
            results_seen++;
            if (pending_results.size() == 0) begin
                report_mismatch("unexpected beat", 64'd0, 64'd0);
            end else begin
                want = pending_results.pop_front();
                if (got.hit != want.hit) report_mismatch("hit", got.hit, want.hit);
                if (got.found_low != want.found_low)
                    report_mismatch("found_low", got.found_low, want.found_low);
                if (got.found_high != want.found_high)
                    report_mismatch("found_high", got.found_high, want.found_high);
                if (got.found_valid != want.found_valid)
                    report_mismatch("found_valid", got.found_valid, want.found_valid);
                if (got.table_changed != want.table_changed)
                    report_mismatch("table_changed", got.table_changed, want.table_changed);
                if (got.table_full != want.table_full)
                    report_mismatch("table_full", got.table_full, want.table_full);
                if (got.entry_count != want.entry_count)
                    report_mismatch("entry_count", got.entry_count, want.entry_count);
                if (got.total_size != want.total_size)
                    report_mismatch("total_size", got.total_size, want.total_size);
            end
        end
    end

    // Randomly stall the result side
    always @(posedge aclk) begin
        if (!aresetn) m_tready <= 1'b0;
        else m_tready <= ($urandom_range(99) >= receiver_idle_pct);
    end

    // Abort if no beat moves on either side for too long
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_CYCLES) begin
            $display("timeout: no beat moved for %0d cycles", WATCHDOG_CYCLES);
            $display("address_range_table verification failed");
            $finish;
        end
    end

    // Addresses drawn from a small pool so ranges collide and merge often
    function automatic logic [63:0] pick_addr();
        case ($urandom_range(9))
            0: return {$urandom, $urandom};
            1: return 64'hFFFF_FFFF_FFFF_FFFF - $urandom_range(40);
            2: return 64'(1) << $urandom_range(63);
            default: return 64'($urandom_range(200));
        endcase
    endfunction

    task automatic test_directed();
        send_op(KIND_QUERY, 64'd5, 64'd0, 1'b0, 8'd0);            // empty table
        send_op(KIND_NTH, 64'd0, 64'd0, 1'b0, 8'd0);              // nth miss on empty
        send_op(KIND_ADD, 64'd10, 64'd20, 1'b0, 8'd0);            // no append allowed
        send_op(KIND_ADD, 64'd20, 64'd10, 1'b1, 8'd0);            // reversed bounds, append
        send_op(KIND_ADD, 64'd10, 64'd20, 1'b1, 8'd0);            // equal range
        send_op(KIND_ADD, 64'd15, 64'd30, 1'b1, 8'd0);            // overlap low side
        send_op(KIND_ADD, 64'd5, 64'd12, 1'b1, 8'd0);             // overlap high side
        send_op(KIND_ADD, 64'd8, 64'd9, 1'b1, 8'd0);              // covered
        send_op(KIND_ADD, 64'd0, 64'd40, 1'b1, 8'd0);             // entry inside range
        send_op(KIND_QUERY, 64'd40, 64'd0, 1'b0, 8'd0);           // inclusive end only
        send_op(KIND_QUERY, 64'd0, 64'd0, 1'b0, 8'd0);
        send_op(KIND_SUB, 64'd20, 64'd20, 1'b0, 8'd0);            // empty subtract
        send_op(KIND_SUB, 64'd10, 64'd15, 1'b0, 8'd0);            // split
        send_op(KIND_SUB, 64'd30, 64'd50, 1'b0, 8'd0);            // trim upper
        send_op(KIND_ADD, 64'd100, 64'd110, 1'b1, 8'd0);
        send_op(KIND_SUB, 64'd90, 64'd120, 1'b0, 8'd0);           // delete inside
        send_op(KIND_ADD, 64'hFFFF_FFFF_FFFF_FFF0, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 8'd0);
        send_op(KIND_ADD, 64'd0, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 8'd0);
        send_op(KIND_NTH, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 8'd0);
        send_op(KIND_NTH, 64'd0, 64'd0, 1'b0, 8'd255);
        send_op(KIND_SUB, 64'hFFFF_FFFF_FFFF_FFFF, 64'd0, 1'b1, 8'd0); // clear nearly all
        wait_drained();
    endtask

    // Fill the table with disjoint ranges, then force an overflowing append and split
    task automatic test_full_table();
        for (int i = 0; i < ENTRIES + 2; i++)
            send_op(KIND_ADD, 64'(1000 + 10 * i), 64'(1005 + 10 * i), 1'b1, 8'($urandom));
        send_op(KIND_SUB, 64'd1001, 64'd1002, 1'b0, 8'd0);       // split with table full
        send_op(KIND_NTH, 64'd0, 64'd0, 1'b0, 8'(ENTRIES - 1));
        send_op(KIND_NTH, 64'd0, 64'd0, 1'b0, 8'(ENTRIES));
        send_op(KIND_SUB, 64'd0, 64'd5000, 1'b0, 8'd0);
        wait_drained();
    endtask

    task automatic test_random(int count);
        logic [63:0] a, b;
        kind_t kind;
        for (int n = 0; n < count; n++) begin
            a = pick_addr();
            b = ($urandom_range(3) == 0) ? pick_addr() : a + 64'($urandom_range(60));
            case ($urandom_range(9))
                0, 1, 2, 3: kind = KIND_ADD;
                4, 5: kind = KIND_SUB;
                6, 7: kind = KIND_QUERY;
                default: kind = KIND_NTH;
            endcase
            send_op(kind, a, b, ($urandom_range(4) != 0), 8'($urandom_range(20)) |
                    (($urandom_range(30) == 0) ? 8'($urandom) : 8'd0));
            // occasionally drain the table to keep all merge cases reachable
            if ($urandom_range(60) == 0) send_op(KIND_SUB, 64'd0, '1, 1'b0, 8'd0);
        end
    endtask

    initial begin
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = KIND_ADD;
        error_count = 0;
        beats_sent = 0;
        results_seen = 0;
        idle_cycles = 0;
        tbl_used = 0;
        kind_seen = '{default: 0};
        for (int i = 0; i < ENTRIES; i++) begin
            tbl_start[i] = '0;
            tbl_end[i] = '0;
        end
        sender_idle_pct = 30;
        receiver_idle_pct = 71;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed();
        test_full_table();
        test_random(330);
        wait_drained();   // sender holds until everything is back
        sender_idle_pct = 71;
        receiver_idle_pct = 30;
        test_random(330);
        sender_idle_pct = 0;
        receiver_idle_pct = 0;
        test_random(300);

        wait_drained();
        repeat (200) @(posedge aclk);
        $display("covered %0d beats: %0d add, %0d subtract, %0d query, %0d nth",
                 beats_sent, kind_seen[KIND_ADD], kind_seen[KIND_SUB],
                 kind_seen[KIND_QUERY], kind_seen[KIND_NTH]);
        $display("checked %0d result beats, %0d mismatches", results_seen, error_count);
        if (error_count == 0 && pending_results.size() == 0) begin
            $display("address_range_table verification clean");
        end else begin
            $display("address_range_table verification failed");
        end
        $finish;
    end
endmodule
